>>> hdl/osu_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// osu_pkg
// Types and constants shared by the oversampled UART and its channel
// interfaces.
// ----------------------------------------------------------------------------
package osu_pkg;

    localparam int OS_W = 7;
    localparam int TICK_W = 8;
    localparam int BIT_W = 4;
    localparam int CNT_W = 6;

    localparam logic [OS_W-1:0] OVERSAMPLE_RESET = 7'd16;
    localparam logic [BIT_W-1:0] BITS_PER_FRAME = 4'd8;

    typedef struct packed {
        logic       rx_line;
        logic       tx_push;
        logic [7:0] tx_byte;
        logic       rx_pop;
    } t_in_item;

    typedef struct packed {
        logic             tx_line;
        logic [7:0]       rx_byte;
        logic             rx_byte_valid;
        logic [CNT_W-1:0] rx_count;
        logic [CNT_W-1:0] tx_count;
    } t_out_item;

    typedef enum logic [2:0] {
        RX_IDLE = 3'b001,
        RX_DATA = 3'b010,
        RX_STOP = 3'b100
    } t_rx_state;

    typedef enum logic [3:0] {
        TX_IDLE  = 4'b0001,
        TX_DATA  = 4'b0010,
        TX_STOP  = 4'b0100,
        TX_TRAIL = 4'b1000
    } t_tx_state;

endpackage

>>> hdl/osu_in_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// osu_in_if
// Valid/ready channel that carries one oversampling tick to the UART.
// ----------------------------------------------------------------------------
interface osu_in_if;
    import osu_pkg::*;

    logic     valid;
    logic     ready;
    t_in_item data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

>>> hdl/osu_out_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// osu_out_if
// Valid/ready channel that carries one per-tick result from the UART.
// ----------------------------------------------------------------------------
interface osu_out_if;
    import osu_pkg::*;

    logic      valid;
    logic      ready;
    t_out_item data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

>>> hdl/oversampled_uart_with_fifos.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// oversampled_uart_with_fifos
// 8N1 UART driven by oversampling ticks, with receive and transmit FIFOs.
// ----------------------------------------------------------------------------
// Each input transaction is one oversampling tick and produces exactly one
// output transaction. The block takes one tick per clock cycle when the output
// side keeps up: a tick sits in an input register, is processed from there once
// the result register is free or being taken, and lands in that register. Each
// FIFO is a memory of FIFO_DEPTH entries with one write port and one read port,
// holding at most FIFO_DEPTH-1 bytes; the entry at the read pointer is
// prefetched into a register every cycle, which is what lets a pop complete
// within one tick.
// Writes to the oversample register should be made only while no tick is in
// flight, and they take effect at the next bit-time reload.
module oversampled_uart_with_fifos #(
    parameter int FIFO_DEPTH = 64
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_cfg_wen,
    input  logic [osu_pkg::OS_W-1:0]   i_cfg_wdata,
    osu_in_if.sink                     i_in,
    osu_out_if.source                  o_out
);
    import osu_pkg::*;

    localparam int AW = $clog2(FIFO_DEPTH);
    localparam int CW = (AW + 1 > CNT_W) ? AW + 1 : CNT_W;
    localparam logic [AW-1:0] LAST = AW'(FIFO_DEPTH - 1);

    function automatic logic [AW-1:0] ptr_inc(input logic [AW-1:0] p);
        return (p == LAST) ? '0 : p + 1'b1;
    endfunction

    logic [OS_W-1:0]   r_os;
    t_in_item          r_in, n_in;
    logic              r_in_vld, n_in_vld;
    t_out_item         r_out, n_out;
    logic              r_out_vld, n_out_vld;

    logic              r_rx_prev, n_rx_prev;
    t_rx_state         r_rx_state, n_rx_state;
    logic [7:0]        r_rx_shift, n_rx_shift;
    logic [BIT_W-1:0]  r_rx_bits, n_rx_bits;
    logic [TICK_W-1:0] r_rx_ticks, n_rx_ticks;

    t_tx_state         r_tx_state, n_tx_state;
    logic [7:0]        r_tx_shift, n_tx_shift;
    logic [BIT_W-1:0]  r_tx_bits, n_tx_bits;
    logic [TICK_W-1:0] r_tx_ticks, n_tx_ticks;
    logic              r_tx_level, n_tx_level;

    logic [7:0]        r_rx_mem [FIFO_DEPTH];
    logic [7:0]        r_tx_mem [FIFO_DEPTH];
    logic [7:0]        r_rx_rd, r_tx_rd;
    logic [AW-1:0]     r_rx_head, n_rx_head, r_rx_tail, n_rx_tail;
    logic [AW-1:0]     r_tx_head, n_tx_head, r_tx_tail, n_tx_tail;

    logic              fire;
    logic              rx_put, rx_we, tx_we;
    logic [TICK_W-1:0] rx_dec, tx_dec;
    logic [BIT_W-1:0]  rx_bits_inc, tx_bits_inc;
    logic [CW-1:0]     rx_cnt, tx_cnt;

    assign fire = r_in_vld && (!r_out_vld || o_out.ready);
    assign i_in.ready = !r_in_vld || fire;
    assign o_out.valid = r_out_vld;
    assign o_out.data = r_out;

    assign rx_dec = r_rx_ticks - 1'b1;
    assign tx_dec = r_tx_ticks - 1'b1;
    assign rx_bits_inc = r_rx_bits + 1'b1;
    assign tx_bits_inc = r_tx_bits + 1'b1;

    always_comb begin
        n_in = r_in;
        n_in_vld = r_in_vld;
        n_out = r_out;
        n_out_vld = r_out_vld;
        n_rx_prev = r_rx_prev;
        n_rx_state = r_rx_state;
        n_rx_shift = r_rx_shift;
        n_rx_bits = r_rx_bits;
        n_rx_ticks = r_rx_ticks;
        n_tx_state = r_tx_state;
        n_tx_shift = r_tx_shift;
        n_tx_bits = r_tx_bits;
        n_tx_ticks = r_tx_ticks;
        n_tx_level = r_tx_level;
        n_rx_head = r_rx_head;
        n_rx_tail = r_rx_tail;
        n_tx_head = r_tx_head;
        n_tx_tail = r_tx_tail;
        rx_put = 1'b0;
        rx_we = 1'b0;
        tx_we = 1'b0;
        rx_cnt = '0;
        tx_cnt = '0;

        if (i_in.valid && i_in.ready) begin
            n_in = i_in.data;
            n_in_vld = 1'b1;
        end else if (fire) begin
            n_in_vld = 1'b0;
        end

        if (fire) begin
            n_rx_prev = r_in.rx_line;
            case (r_rx_state)
                RX_DATA: begin
                    n_rx_ticks = rx_dec;
                    if (rx_dec == '0) begin
                        n_rx_shift = {r_in.rx_line, r_rx_shift[7:1]};
                        n_rx_bits = rx_bits_inc;
                        n_rx_ticks = TICK_W'(r_os);
                        if (rx_bits_inc == BITS_PER_FRAME) begin
                            n_rx_state = RX_STOP;
                        end
                    end
                end
                RX_STOP: begin
                    n_rx_ticks = rx_dec;
                    if (rx_dec == '0) begin
                        rx_put = r_in.rx_line;
                        n_rx_state = RX_IDLE;
                    end
                end
                default: begin
                    n_rx_state = RX_IDLE;
                    if (r_rx_prev && !r_in.rx_line) begin
                        n_rx_state = RX_DATA;
                        n_rx_shift = '0;
                        n_rx_bits = '0;
                        n_rx_ticks = TICK_W'(r_os) + TICK_W'(r_os[OS_W-1:1]);
                    end
                end
            endcase

            if (rx_put && ptr_inc(r_rx_head) != r_rx_tail) begin
                rx_we = 1'b1;
                n_rx_head = ptr_inc(r_rx_head);
            end

            case (r_tx_state)
                TX_DATA: begin
                    n_tx_ticks = tx_dec;
                    if (tx_dec == '0) begin
                        n_tx_level = r_tx_shift[0];
                        n_tx_shift = {1'b0, r_tx_shift[7:1]};
                        n_tx_ticks = TICK_W'(r_os);
                        n_tx_bits = tx_bits_inc;
                        if (tx_bits_inc == BITS_PER_FRAME) begin
                            n_tx_state = TX_STOP;
                        end
                    end
                end
                TX_STOP: begin
                    n_tx_ticks = tx_dec;
                    if (tx_dec == '0) begin
                        n_tx_level = 1'b1;
                        n_tx_ticks = TICK_W'(r_os);
                        n_tx_state = TX_TRAIL;
                    end
                end
                TX_TRAIL: begin
                    n_tx_ticks = tx_dec;
                    if (tx_dec == '0) begin
                        n_tx_state = TX_IDLE;
                    end
                end
                default: begin
                    if (r_tx_head != r_tx_tail) begin
                        n_tx_shift = r_tx_rd;
                        n_tx_ticks = TICK_W'(r_os);
                        n_tx_level = 1'b0;
                        n_tx_state = TX_DATA;
                        n_tx_bits = '0;
                        n_tx_tail = ptr_inc(r_tx_tail);
                    end
                end
            endcase

            if (r_in.tx_push && ptr_inc(r_tx_head) != n_tx_tail) begin
                tx_we = 1'b1;
                n_tx_head = ptr_inc(r_tx_head);
            end

            n_out.rx_byte = '0;
            n_out.rx_byte_valid = 1'b0;
            if (r_in.rx_pop && n_rx_head != r_rx_tail) begin
                n_out.rx_byte = (r_rx_head == r_rx_tail) ? r_rx_shift : r_rx_rd;
                n_out.rx_byte_valid = 1'b1;
                n_rx_tail = ptr_inc(r_rx_tail);
            end

            rx_cnt = CW'(n_rx_head) - CW'(n_rx_tail)
                     + ((n_rx_head < n_rx_tail) ? CW'(FIFO_DEPTH) : CW'(0));
            tx_cnt = CW'(n_tx_head) - CW'(n_tx_tail)
                     + ((n_tx_head < n_tx_tail) ? CW'(FIFO_DEPTH) : CW'(0));

            n_out.tx_line = n_tx_level;
            n_out.rx_count = rx_cnt[CNT_W-1:0];
            n_out.tx_count = tx_cnt[CNT_W-1:0];
            n_out_vld = 1'b1;
        end else if (o_out.ready) begin
            n_out_vld = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (rx_we) begin
            r_rx_mem[r_rx_head] <= r_rx_shift;
        end
        if (rx_we && r_rx_head == n_rx_tail) begin
            r_rx_rd <= r_rx_shift;
        end else begin
            r_rx_rd <= r_rx_mem[n_rx_tail];
        end
    end

    always_ff @(posedge i_clk) begin
        if (tx_we) begin
            r_tx_mem[r_tx_head] <= r_in.tx_byte;
        end
        if (tx_we && r_tx_head == n_tx_tail) begin
            r_tx_rd <= r_in.tx_byte;
        end else begin
            r_tx_rd <= r_tx_mem[n_tx_tail];
        end
    end

    always_ff @(posedge i_clk) begin
        r_in <= n_in;
        r_out <= n_out;
        r_rx_shift <= n_rx_shift;
        r_tx_shift <= n_tx_shift;
        if (!i_rst_n) begin
            r_os <= OVERSAMPLE_RESET;
            r_in_vld <= 1'b0;
            r_out_vld <= 1'b0;
            r_rx_prev <= 1'b1;
            r_rx_state <= RX_IDLE;
            r_rx_bits <= '0;
            r_rx_ticks <= '0;
            r_tx_state <= TX_IDLE;
            r_tx_bits <= '0;
            r_tx_ticks <= '0;
            r_tx_level <= 1'b1;
            r_rx_head <= '0;
            r_rx_tail <= '0;
            r_tx_head <= '0;
            r_tx_tail <= '0;
        end else begin
            if (i_cfg_wen) begin
                r_os <= i_cfg_wdata;
            end
            r_in_vld <= n_in_vld;
            r_out_vld <= n_out_vld;
            r_rx_prev <= n_rx_prev;
            r_rx_state <= n_rx_state;
            r_rx_bits <= n_rx_bits;
            r_rx_ticks <= n_rx_ticks;
            r_tx_state <= n_tx_state;
            r_tx_bits <= n_tx_bits;
            r_tx_ticks <= n_tx_ticks;
            r_tx_level <= n_tx_level;
            r_rx_head <= n_rx_head;
            r_rx_tail <= n_rx_tail;
            r_tx_head <= n_tx_head;
            r_tx_tail <= n_tx_tail;
        end
    end

`ifndef SYNTH
    a_tx_idle_high: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_tx_state == TX_IDLE || r_tx_state == TX_TRAIL) |-> r_tx_level)
        else $error("Transmit line is low outside a frame.");

    a_rx_stop_bits: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_rx_state == RX_STOP) |-> (r_rx_bits == BITS_PER_FRAME))
        else $error("Receiver reached the stop bit without eight data bits.");

    a_ptr_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_rx_head <= LAST) && (r_rx_tail <= LAST)
        && (r_tx_head <= LAST) && (r_tx_tail <= LAST))
        else $error("FIFO pointer left the ring.");

    a_result_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_vld && !o_out.ready) |=> $stable(r_out))
        else $error("Result register changed while stalled.");
`endif

endmodule

>>> tb/oversampled_uart_with_fifos_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// oversampled_uart_with_fifos_tb
// Self-checking testbench for the oversampled 8N1 UART with its two FIFOs.
// A scoreboard class predicts the result of every accepted tick from its own
// copy of the receiver, transmitter and FIFO state. It compares each result
// transaction field by field, in order. The stimulus starts with a few
// directed ticks. Random phases follow at several oversample settings, the
// extremes among them. The receive line carries mostly well-formed frames,
// with noise and bad stop bits mixed in. Both channel sides idle and stall at
// random.
// ----------------------------------------------------------------------------
module oversampled_uart_with_fifos_tb;
    import osu_pkg::*;

    localparam int FIFO_DEPTH = 64;

    class uart_scoreboard;
        logic [OS_W-1:0]   oversample;
        logic              rx_prev;
        t_rx_state         rx_state;
        logic [7:0]        rx_shift;
        logic [BIT_W-1:0]  rx_bits;
        logic [TICK_W-1:0] rx_ticks;
        t_tx_state         tx_state;
        logic [7:0]        tx_shift;
        logic [BIT_W-1:0]  tx_bits;
        logic [TICK_W-1:0] tx_ticks;
        logic              tx_level;
        logic [7:0]        rx_fifo[$];
        logic [7:0]        tx_fifo[$];
        t_out_item         tick_results[$];
        int                fifo_room;
        int                errors;

        function new(int depth);
            fifo_room = depth - 1;
            oversample = OVERSAMPLE_RESET;
            rx_prev = 1'b1;
            rx_state = RX_IDLE;
            rx_shift = '0;
            rx_bits = '0;
            rx_ticks = '0;
            tx_state = TX_IDLE;
            tx_shift = '0;
            tx_bits = '0;
            tx_ticks = '0;
            tx_level = 1'b1;
            errors = 0;
        endfunction

        function int pending();
            return tick_results.size();
        endfunction

        // The first sample of a frame sits one and a half bit times after the edge.
        function logic [TICK_W-1:0] bit_ticks(bit first);
            logic [TICK_W-1:0] ticks;
            ticks = TICK_W'(oversample);
            if (first) begin
                ticks = ticks + TICK_W'(oversample >> 1);
            end
            return ticks;
        endfunction

        function void note_tick(t_in_item tick);
            t_out_item res;
            logic      prev;
            prev = rx_prev;
            rx_prev = tick.rx_line;
            res = '0;
            case (rx_state)
                RX_DATA: begin
                    rx_ticks = rx_ticks - 1'b1;
                    if (rx_ticks == '0) begin
                        rx_shift = {tick.rx_line, rx_shift[7:1]};
                        rx_bits = rx_bits + 1'b1;
                        if (rx_bits == BITS_PER_FRAME) begin
                            rx_state = RX_STOP;
                        end
                        rx_ticks = bit_ticks(1'b0);
                    end
                end
                RX_STOP: begin
                    rx_ticks = rx_ticks - 1'b1;
                    if (rx_ticks == '0) begin
                        if (tick.rx_line && rx_fifo.size() < fifo_room) begin
                            rx_fifo.push_back(rx_shift);
                        end
                        rx_state = RX_IDLE;
                    end
                end
                default: begin
                    rx_state = RX_IDLE;
                    if (prev && !tick.rx_line) begin
                        rx_state = RX_DATA;
                        rx_shift = '0;
                        rx_bits = '0;
                        rx_ticks = bit_ticks(1'b1);
                    end
                end
            endcase

            if (tx_state == TX_IDLE) begin
                if (tx_fifo.size() != 0) begin
                    tx_shift = tx_fifo.pop_front();
                    tx_ticks = bit_ticks(1'b0);
                    tx_level = 1'b0;
                    tx_state = TX_DATA;
                    tx_bits = '0;
                end
            end else begin
                tx_ticks = tx_ticks - 1'b1;
                if (tx_ticks == '0) begin
                    case (tx_state)
                        TX_DATA: begin
                            tx_level = tx_shift[0];
                            tx_shift = tx_shift >> 1;
                            tx_ticks = bit_ticks(1'b0);
                            tx_bits = tx_bits + 1'b1;
                            if (tx_bits == BITS_PER_FRAME) begin
                                tx_state = TX_STOP;
                            end
                        end
                        TX_STOP: begin
                            tx_level = 1'b1;
                            tx_ticks = bit_ticks(1'b0);
                            tx_state = TX_TRAIL;
                        end
                        default: begin
                            tx_state = TX_IDLE;
                        end
                    endcase
                end
            end

            if (tick.tx_push && tx_fifo.size() < fifo_room) begin
                tx_fifo.push_back(tick.tx_byte);
            end
            if (tick.rx_pop && rx_fifo.size() != 0) begin
                res.rx_byte = rx_fifo.pop_front();
                res.rx_byte_valid = 1'b1;
            end
            res.tx_line = tx_level;
            res.rx_count = CNT_W'(rx_fifo.size());
            res.tx_count = CNT_W'(tx_fifo.size());
            tick_results.push_back(res);
        endfunction

        task report(string msg);
            errors++;
            if (errors <= 40) begin
                $display("[%0t] mismatch: %s", $time, msg);
            end
        endtask

        task check_result(t_out_item got);
            t_out_item want;
            if (tick_results.size() == 0) begin
                report("result transaction with no tick outstanding");
                return;
            end
            want = tick_results.pop_front();
            if (got.tx_line !== want.tx_line) begin
                report($sformatf("tx_line %b, expected %b", got.tx_line, want.tx_line));
            end
            if (got.rx_byte !== want.rx_byte) begin
                report($sformatf("rx_byte %h, expected %h", got.rx_byte, want.rx_byte));
            end
            if (got.rx_byte_valid !== want.rx_byte_valid) begin
                report($sformatf("rx_byte_valid %b, expected %b",
                                 got.rx_byte_valid, want.rx_byte_valid));
            end
            if (got.rx_count !== want.rx_count) begin
                report($sformatf("rx_count %0d, expected %0d", got.rx_count, want.rx_count));
            end
            if (got.tx_count !== want.tx_count) begin
                report($sformatf("tx_count %0d, expected %0d", got.tx_count, want.tx_count));
            end
        endtask
    endclass

    logic              i_clk = 1'b0;
    logic              i_rst_n;
    logic              cfg_wen;
    logic [OS_W-1:0]   cfg_wdata;
    int                send_gap = 0;
    int                sink_stall = 0;
    bit                line_plan[$];
    uart_scoreboard    uart_check;

    osu_in_if  in_ch ();
    osu_out_if out_ch ();

    oversampled_uart_with_fifos #(
        .FIFO_DEPTH(FIFO_DEPTH)
    ) u_dut (
        .i_clk(i_clk),
        .i_rst_n(i_rst_n),
        .i_cfg_wen(cfg_wen),
        .i_cfg_wdata(cfg_wdata),
        .i_in(in_ch),
        .o_out(out_ch)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    function automatic t_in_item tick_item(bit line, bit push, logic [7:0] data, bit pop);
        t_in_item tick;
        tick.rx_line = line;
        tick.tx_push = push;
        tick.tx_byte = data;
        tick.rx_pop = pop;
        return tick;
    endfunction

    // Queues the receive line levels of one frame, sometimes a burst of noise instead.
    function automatic void plan_frame(int bit_len);
        logic [7:0] data;
        bit         stop;
        data = 8'($urandom_range(255));
        if ($urandom_range(99) < 4) begin
            repeat ($urandom_range(1, 6)) line_plan.push_back(1'($urandom_range(1)));
            return;
        end
        stop = ($urandom_range(99) >= 6);
        repeat ($urandom_range(0, 1)) line_plan.push_back(1'b1);
        repeat (bit_len) line_plan.push_back(1'b0);
        for (int i = 0; i < 8; i++) begin
            repeat (bit_len) line_plan.push_back(data[i]);
        end
        repeat (bit_len) line_plan.push_back(stop);
    endfunction

    task automatic send_tick(t_in_item tick);
        while ($urandom_range(99) < send_gap) begin
            in_ch.valid <= 1'b0;
            @(posedge i_clk);
        end
        in_ch.valid <= 1'b1;
        in_ch.data <= tick;
        @(posedge i_clk);
        while (!in_ch.ready) @(posedge i_clk);
        uart_check.note_tick(tick);
    endtask

    task automatic write_oversample(logic [OS_W-1:0] value);
        while (uart_check.pending() != 0) @(posedge i_clk);
        cfg_wen <= 1'b1;
        cfg_wdata <= value;
        @(posedge i_clk);
        cfg_wen <= 1'b0;
        uart_check.oversample = value;
    endtask

    task automatic run_phase(int os, bit write, int ticks, int push_pct, int pop_pct,
                             int mode);
        t_in_item tick;
        int       bit_len;
        if (write) begin
            write_oversample(os[OS_W-1:0]);
        end
        send_gap = (mode == 1) ? 64 : (mode == 3) ? 24 : 0;
        sink_stall = (mode == 2) ? 64 : (mode == 3) ? 24 : 0;
        bit_len = (os == 0) ? 256 : os;
        line_plan.delete();
        repeat (ticks) begin
            if (line_plan.size() == 0) begin
                plan_frame(bit_len);
            end
            tick.rx_line = line_plan.pop_front();
            tick.tx_push = ($urandom_range(99) < push_pct);
            tick.tx_byte = 8'($urandom_range(255));
            tick.rx_pop = ($urandom_range(99) < pop_pct);
            send_tick(tick);
        end
        in_ch.valid <= 1'b0;
    endtask

    initial begin
        out_ch.ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (i_rst_n && out_ch.valid && out_ch.ready) begin
                uart_check.check_result(out_ch.data);
            end
            out_ch.ready <= ($urandom_range(99) >= sink_stall);
        end
    end

    initial begin
        uart_check = new(FIFO_DEPTH);
        i_rst_n <= 1'b0;
        cfg_wen <= 1'b0;
        cfg_wdata <= '0;
        in_ch.valid <= 1'b0;
        in_ch.data <= '0;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        send_tick(tick_item(1'b1, 1'b0, 8'h00, 1'b1));
        send_tick(tick_item(1'b1, 1'b1, 8'h00, 1'b0));
        send_tick(tick_item(1'b1, 1'b1, 8'hFF, 1'b0));
        send_tick(tick_item(1'b1, 1'b1, 8'hA5, 1'b1));
        send_tick(tick_item(1'b0, 1'b1, 8'h5A, 1'b1));
        send_tick(tick_item(1'b0, 1'b0, 8'h00, 1'b0));
        send_tick(tick_item(1'b1, 1'b1, 8'h01, 1'b0));
        send_tick(tick_item(1'b1, 1'b1, 8'h80, 1'b1));
        send_tick(tick_item(1'b1, 1'b0, 8'hFF, 1'b0));
        send_tick(tick_item(1'b0, 1'b0, 8'hFF, 1'b1));
        send_tick(tick_item(1'b1, 1'b0, 8'h00, 1'b0));

        run_phase(16, 1'b0, 150, 30, 30, 0);
        run_phase(2, 1'b1, 250, 80, 0, 1);
        run_phase(1, 1'b1, 400, 10, 0, 2);
        run_phase(3, 1'b1, 200, 5, 70, 3);
        run_phase(127, 1'b1, 400, 20, 20, 0);
        run_phase(0, 1'b1, 150, 20, 20, 1);
        run_phase(5, 1'b1, 150, 40, 40, 2);

        while (uart_check.pending() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
        if (uart_check.errors == 0 && uart_check.pending() == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

    initial begin
        #(5_000_000);
        $display("Verification failed");
        $finish;
    end

endmodule

>>> oversampled_uart_with_fifos.f
hdl/osu_pkg.sv
hdl/osu_in_if.sv
hdl/osu_out_if.sv
hdl/oversampled_uart_with_fifos.sv
tb/oversampled_uart_with_fifos_tb.sv
